// File: rtl/core/spfa_pkg.sv
// ----------------------------------------------------------------------------
// spfa_pkg
// Shared types, constants and curve tables of the spectral photon flux
// accumulator.
// ----------------------------------------------------------------------------
package spfa_pkg;

  localparam int unsigned WL_W     = 18;
  localparam int unsigned BW_W     = 12;
  localparam int unsigned E_W      = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned CRV_W    = 17;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned MUL_A_W  = 39;
  localparam int unsigned MUL_B_W  = 28;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam int unsigned DIV_N_W  = 52;
  localparam int unsigned DIV_D_W  = 13;
  localparam int unsigned DIV_C_W  = 6;

  localparam int unsigned Q_W      = 38;
  localparam int unsigned OV_W     = 13;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned STEP_W   = 11;
  localparam int unsigned OFF_W    = 15;

  localparam logic [MUL_B_W-1:0] KPH      = 28'd143612471;
  localparam logic [MUL_B_W-1:0] LUX_GAIN = 28'd683;
  localparam logic [SUM_W-1:0]   MAX48    = {SUM_W{1'b1}};
  localparam logic [WL_W-1:0]    MAX18    = {WL_W{1'b1}};

  localparam int unsigned LUM_POINTS = 81;
  localparam int unsigned ACT_POINTS = 17;
  localparam int unsigned LUM_IDX_W  = 7;
  localparam int unsigned ACT_IDX_W  = 5;

  localparam logic [OFF_W-1:0]  LUM_START = 15'd24320;
  localparam logic [STEP_W-1:0] LUM_STEP  = 11'd320;
  localparam logic [OFF_W-1:0]  ACT_START = 15'd22400;
  localparam logic [STEP_W-1:0] ACT_STEP  = 11'd1600;
  localparam logic [OFF_W-1:0]  LUM_SPAN  = OFF_W'((LUM_POINTS - 1) * 320);
  localparam logic [OFF_W-1:0]  ACT_SPAN  = OFF_W'((ACT_POINTS - 1) * 1600);
  localparam logic [IDX_W-1:0]  LUM_LAST  = IDX_W'(LUM_POINTS - 1);
  localparam logic [IDX_W-1:0]  ACT_LAST  = IDX_W'(ACT_POINTS - 1);

  // division by a table step: drop the six low bits, then multiply by the
  // reciprocal of step/64 and shift; exact for every value the curves see
  localparam int unsigned       STEP_SH    = 6;
  localparam int unsigned       RCP_Q_W    = 22;
  localparam logic [MUL_B_W-1:0] LUM_RCP   = 28'd3355444;
  localparam logic [MUL_B_W-1:0] ACT_RCP   = 28'd2684355;
  localparam int unsigned       LUM_RCP_SH = 24;
  localparam int unsigned       ACT_RCP_SH = 26;

  localparam logic [2:0] REG_START    = 3'd0;
  localparam logic [2:0] REG_BIN_W    = 3'd1;
  localparam logic [2:0] REG_PAR_LOW  = 3'd2;
  localparam logic [2:0] REG_PAR_HIGH = 3'd3;
  localparam logic [2:0] REG_EXT_HIGH = 3'd4;

  localparam logic [CRV_W-1:0] LUM_ROM [LUM_POINTS] = '{
    17'd3, 17'd4, 17'd8, 17'd14, 17'd26, 17'd42, 17'd79, 17'd143,
    17'd262, 17'd478, 17'd760, 17'd1104, 17'd1507, 17'd1953, 17'd2490, 17'd3146,
    17'd3932, 17'd4843, 17'd5962, 17'd7379, 17'd9111, 17'd11095, 17'd13633, 17'd16948,
    17'd21168, 17'd26693, 17'd32965, 17'd39859, 17'd46531, 17'd51983, 17'd56492,
    17'd59956, 17'd62521, 17'd64245, 17'd65205, 17'd65536, 17'd65208, 17'd64134,
    17'd62390, 17'd59992, 17'd57016, 17'd53497, 17'd49611, 17'd45541, 17'd41353,
    17'd37146, 17'd32965, 17'd28914, 17'd24969, 17'd21037, 17'd17367, 17'd14221,
    17'd11469, 17'd9057, 17'd7012, 17'd5348, 17'd3998, 17'd2922, 17'd2097, 17'd1520,
    17'd1114, 17'd781, 17'd538, 17'd375, 17'd269, 17'd192, 17'd137, 17'd97,
    17'd69, 17'd48, 17'd34, 17'd24, 17'd16, 17'd11, 17'd8, 17'd6,
    17'd4, 17'd3, 17'd2, 17'd1, 17'd1
  };

  localparam logic [CRV_W-1:0] ACT_ROM [ACT_POINTS] = '{
    17'd19661, 17'd36045, 17'd43254, 17'd45875, 17'd47841, 17'd47841, 17'd46531,
    17'd49152, 17'd52429, 17'd57672, 17'd62915, 17'd65536, 17'd64225, 17'd58982,
    17'd31457, 17'd8520, 17'd1966
  };

  typedef struct packed {
    logic [WL_W-1:0] start_wavelength;
    logic [BW_W-1:0] bin_width;
    logic [WL_W-1:0] par_low;
    logic [WL_W-1:0] par_high;
    logic [WL_W-1:0] extended_high;
  } spfa_cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PQ_EL,
    ST_PQ_LO,
    ST_PQ_HI,
    ST_PQ_SUM,
    ST_BD_MUL,
    ST_BD_DIV,
    ST_BD_WAIT,
    ST_CV_CHK,
    ST_CV_IDX,
    ST_CV_M1,
    ST_CV_M2,
    ST_CV_SUM,
    ST_CV_DIV,
    ST_CV_END,
    ST_YIELD,
    ST_LUMW,
    ST_ACC,
    ST_LUX,
    ST_OUT
  } spfa_state_e;

  function automatic logic [CRV_W-1:0] rom_at(input logic lum_sel,
                                              input logic [IDX_W-1:0] idx);
    logic [CRV_W-1:0] v;
    v = '0;
    if (lum_sel) begin
      if (idx < IDX_W'(LUM_POINTS)) v = LUM_ROM[idx[LUM_IDX_W-1:0]];
    end else begin
      if (idx < IDX_W'(ACT_POINTS)) v = ACT_ROM[idx[ACT_IDX_W-1:0]];
    end
    return v;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [SUM_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[SUM_W] ? MAX48 : t[SUM_W-1:0];
  endfunction

endpackage

// File: rtl/core/spfa_if.sv
// ----------------------------------------------------------------------------
// spfa_if
// Valid/ready channels for input bins and result beats.
// ----------------------------------------------------------------------------
interface spfa_in_if;
  import spfa_pkg::*;
  logic            valid;
  logic            ready;
  logic [E_W-1:0]  bin_irradiance;
  logic            last_bin;
  modport source (output valid, bin_irradiance, last_bin, input ready);
  modport sink   (input valid, bin_irradiance, last_bin, output ready);
endinterface

interface spfa_out_if;
  import spfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  par_flux;
  logic [SUM_W-1:0]  extended_flux;
  logic [SUM_W-1:0]  yield_flux;
  logic [SUM_W-1:0]  illuminance;
  logic [SUM_W-1:0]  total_irradiance;
  modport source (output valid, par_flux, extended_flux, yield_flux, illuminance,
                  total_irradiance, input ready);
  modport sink   (input valid, par_flux, extended_flux, yield_flux, illuminance,
                  total_irradiance, output ready);
endinterface

// File: rtl/core/spfa_regs.sv
// ----------------------------------------------------------------------------
// spfa_regs
// APB configuration registers for grid and band edges.
// ----------------------------------------------------------------------------
module spfa_regs import spfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output spfa_cfg_t         cfg_o
);

  spfa_cfg_t  cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_wavelength <= WL_W'(24320);
      cfg_q.bin_width        <= BW_W'(320);
      cfg_q.par_low          <= WL_W'(25600);
      cfg_q.par_high         <= WL_W'(44800);
      cfg_q.extended_high    <= WL_W'(48000);
    end else if (wr_en) begin
      case (idx)
        REG_START:    cfg_q.start_wavelength <= pwdata[WL_W-1:0];
        REG_BIN_W:    cfg_q.bin_width        <= pwdata[BW_W-1:0];
        REG_PAR_LOW:  cfg_q.par_low          <= pwdata[WL_W-1:0];
        REG_PAR_HIGH: cfg_q.par_high         <= pwdata[WL_W-1:0];
        REG_EXT_HIGH: cfg_q.extended_high    <= pwdata[WL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START:    prdata = DATA_W'(cfg_q.start_wavelength);
      REG_BIN_W:    prdata = DATA_W'(cfg_q.bin_width);
      REG_PAR_LOW:  prdata = DATA_W'(cfg_q.par_low);
      REG_PAR_HIGH: prdata = DATA_W'(cfg_q.par_high);
      REG_EXT_HIGH: prdata = DATA_W'(cfg_q.extended_high);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/spfa_mul.sv
// ----------------------------------------------------------------------------
// spfa_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module spfa_mul import spfa_pkg::*; (
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_q;
  logic [MUL_P_W-1:0] p_d;

  assign p_d = MUL_P_W'(a_i) * MUL_P_W'(b_i);
  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

endmodule

// File: rtl/core/spfa_div.sv
// ----------------------------------------------------------------------------
// spfa_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spfa_div import spfa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [DIV_D_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quot_o
);

  logic               busy_q, busy_d, done_q, done_d;
  logic [DIV_C_W-1:0] cnt_q, cnt_d;
  logic [DIV_N_W-1:0] quo_q, quo_d;
  logic [DIV_D_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DIV_D_W:0]   sh;
  logic [DIV_D_W:0]   diff;

  assign sh     = {rem_q, quo_q[DIV_N_W-1]};
  assign diff   = sh - {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_C_W'(DIV_N_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (sh >= {1'b0, dvs_q}) begin
        rem_d = diff[DIV_D_W-1:0];
        quo_d = {quo_q[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_d = sh[DIV_D_W-1:0];
        quo_d = {quo_q[DIV_N_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_C_W'(1);
      if (cnt_q == DIV_C_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

// File: rtl/core/spectral_photon_flux_accumulator_top.sv
// ----------------------------------------------------------------------------
// spectral_photon_flux_accumulator_top
// Per-bin photon flux, band weighting, curve weighting and five running sums.
// ----------------------------------------------------------------------------
// The input is ready only in the idle state, so it is not ready while a bin
// beat is processed. How long a bin beat takes depends on the shared 52-step
// restoring divider for the division by the bin width, used once per
// nonempty band overlap (an empty overlap skips it), and on the two curve
// lookups, whose divisions by the table step are reciprocal products on the
// shared registered multiplier. A last bin adds the lux scale and the result
// load, and waits at the lux scale while an earlier result beat still waits;
// the result register lets the next bin start while the result beat still
// waits.
module spectral_photon_flux_accumulator_top import spfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  spfa_in_if.sink           bin_i,
  spfa_out_if.source        res_o
);

  spfa_cfg_t          cfg;
  spfa_state_e        state_q, state_d;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_num, div_quot;
  logic [DIV_D_W-1:0] div_den;

  logic [E_W-1:0]     e_q;
  logic               last_q;
  logic [WL_W-1:0]    lam_q, cur_q;
  logic [15:0]        cnt_q;
  logic [17:0]        ahi_q;
  logic [27:0]        t_q;
  logic [Q_W-1:0]     q_q, pp_q, ep_q, yp_q;
  logic [32:0]        lp_q;
  logic               band_sel_q, crv_sel_q;
  logic [IDX_W-1:0]   i_q;
  logic [STEP_W-1:0]  f_q;
  logic [CRV_W-1:0]   cval_q;
  logic [SUM_W-1:0]   par_sum_q, ext_sum_q, yld_sum_q, lum_sum_q, nrg_sum_q;
  logic               out_valid_q;
  logic [SUM_W-1:0]   o_par_q, o_ext_q, o_yld_q, o_lux_q, o_nrg_q;

  logic signed [20:0] b1, b2, bl, bh, ba, bz, bov;
  logic               ov_ok;
  logic [OV_W-1:0]    ov;
  logic [OFF_W-1:0]   c_start, c_span;
  logic [STEP_W-1:0]  c_step;
  logic [IDX_W-1:0]   c_last;
  logic [WL_W-1:0]    c_off;
  logic               c_in;
  logic [MUL_B_W-1:0] c_rcp;
  logic [RCP_Q_W-1:0] c_quo;
  logic [WL_W-1:0]    c_mod;
  logic [46:0]        pq_sum;
  logic [28:0]        cv_num;
  logic [WL_W:0]      nxt_wl;

  spfa_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  spfa_mul u_mul (
    .clk_i,
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  spfa_div u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // band overlap in 1/128 nm
  always_comb begin
    b1  = $signed({2'b00, lam_q, 1'b0}) - $signed({9'd0, cfg.bin_width});
    b2  = $signed({2'b00, lam_q, 1'b0}) + $signed({9'd0, cfg.bin_width});
    bl  = $signed({2'b00, cfg.par_low, 1'b0});
    bh  = band_sel_q ? $signed({2'b00, cfg.extended_high, 1'b0})
                     : $signed({2'b00, cfg.par_high, 1'b0});
    ba  = (b1 > bl) ? b1 : bl;
    bz  = (b2 < bh) ? b2 : bh;
    bov = bz - ba;
    ov_ok = (bz > ba) && (cfg.bin_width != '0);
    ov  = bov[OV_W-1:0];
  end

  // curve selection and division by the table step
  always_comb begin
    c_start = crv_sel_q ? LUM_START : ACT_START;
    c_step  = crv_sel_q ? LUM_STEP  : ACT_STEP;
    c_span  = crv_sel_q ? LUM_SPAN  : ACT_SPAN;
    c_last  = crv_sel_q ? LUM_LAST  : ACT_LAST;
    c_rcp   = crv_sel_q ? LUM_RCP   : ACT_RCP;
    c_off   = lam_q - WL_W'(c_start);
    c_in    = (lam_q >= WL_W'(c_start)) && (c_off <= WL_W'(c_span));
    c_quo   = crv_sel_q ? prod[LUM_RCP_SH +: RCP_Q_W] : prod[ACT_RCP_SH +: RCP_Q_W];
    c_mod   = c_off - WL_W'(c_quo[IDX_W-1:0]) * WL_W'(c_step);
  end

  assign pq_sum = prod[45:0] + 47'(t_q);
  assign cv_num = 29'(prod[27:0]) + 29'(t_q);
  assign nxt_wl = {1'b0, lam_q} + (WL_W+1)'(cfg.bin_width);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (bin_i.valid) state_d = ST_PQ_EL;
      ST_PQ_EL:   state_d = ST_PQ_LO;
      ST_PQ_LO:   state_d = ST_PQ_HI;
      ST_PQ_HI:   state_d = ST_PQ_SUM;
      ST_PQ_SUM:  state_d = ST_BD_MUL;
      ST_BD_MUL: begin
        if (ov_ok) state_d = ST_BD_DIV;
        else if (!band_sel_q) state_d = ST_BD_MUL;
        else state_d = ST_CV_CHK;
      end
      ST_BD_DIV:  state_d = ST_BD_WAIT;
      ST_BD_WAIT: begin
        if (div_done) state_d = band_sel_q ? ST_CV_CHK : ST_BD_MUL;
      end
      ST_CV_CHK:  state_d = c_in ? ST_CV_IDX : ST_CV_END;
      ST_CV_IDX:  state_d = (c_quo[IDX_W-1:0] >= c_last) ? ST_CV_END : ST_CV_M1;
      ST_CV_M1:   state_d = ST_CV_M2;
      ST_CV_M2:   state_d = ST_CV_SUM;
      ST_CV_SUM:  state_d = ST_CV_DIV;
      ST_CV_DIV:  state_d = ST_CV_END;
      ST_CV_END:  state_d = crv_sel_q ? ST_LUMW : ST_YIELD;
      ST_YIELD:   state_d = ST_CV_CHK;
      ST_LUMW:    state_d = ST_ACC;
      ST_ACC:     state_d = last_q ? ST_LUX : ST_IDLE;
      ST_LUX:     if (!out_valid_q || res_o.ready) state_d = ST_OUT;
      ST_OUT:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      ST_PQ_EL: begin
        mul_a = MUL_A_W'(e_q);
        mul_b = MUL_B_W'(lam_q);
      end
      ST_PQ_LO: begin
        mul_a = MUL_A_W'(prod[31:0]);
        mul_b = KPH;
      end
      ST_PQ_HI: begin
        mul_a = MUL_A_W'(ahi_q);
        mul_b = KPH;
      end
      ST_BD_MUL: begin
        mul_a = MUL_A_W'(q_q);
        mul_b = MUL_B_W'(ov);
      end
      ST_BD_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_N_W'(prod[50:0]);
        div_den   = {cfg.bin_width, 1'b0};
      end
      ST_CV_CHK: begin
        mul_a = MUL_A_W'(c_off[WL_W-1:STEP_SH]);
        mul_b = c_rcp;
      end
      ST_CV_M1: begin
        mul_a = MUL_A_W'(rom_at(crv_sel_q, i_q));
        mul_b = MUL_B_W'(c_step - f_q);
      end
      ST_CV_M2: begin
        mul_a = MUL_A_W'(rom_at(crv_sel_q, i_q + IDX_W'(1)));
        mul_b = MUL_B_W'(f_q);
      end
      ST_CV_SUM: begin
        mul_a = MUL_A_W'(cv_num[28:STEP_SH]);
        mul_b = c_rcp;
      end
      ST_CV_END: begin
        mul_a = crv_sel_q ? MUL_A_W'(e_q) : MUL_A_W'(pp_q);
        mul_b = MUL_B_W'(cval_q);
      end
      ST_LUX: begin
        mul_a = lum_sum_q[MUL_A_W-1:0];
        mul_b = LUX_GAIN;
      end
      default: ;
    endcase
  end

  assign bin_i.ready            = (state_q == ST_IDLE);
  assign res_o.valid            = out_valid_q;
  assign res_o.par_flux         = o_par_q;
  assign res_o.extended_flux    = o_ext_q;
  assign res_o.yield_flux       = o_yld_q;
  assign res_o.illuminance      = o_lux_q;
  assign res_o.total_irradiance = o_nrg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      cur_q       <= '0;
      par_sum_q   <= '0;
      ext_sum_q   <= '0;
      yld_sum_q   <= '0;
      lum_sum_q   <= '0;
      nrg_sum_q   <= '0;
      band_sel_q  <= 1'b0;
      crv_sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && res_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_PQ_SUM: band_sel_q <= 1'b0;
        ST_BD_MUL: if (!ov_ok) band_sel_q <= 1'b1;
        ST_BD_WAIT: if (div_done) band_sel_q <= 1'b1;
        ST_YIELD: crv_sel_q <= 1'b1;
        ST_ACC: begin
          par_sum_q <= sat_add(par_sum_q, SUM_W'(pp_q));
          ext_sum_q <= sat_add(ext_sum_q, SUM_W'(ep_q));
          yld_sum_q <= sat_add(yld_sum_q, SUM_W'(yp_q));
          lum_sum_q <= sat_add(lum_sum_q, SUM_W'(lp_q));
          nrg_sum_q <= sat_add(nrg_sum_q, SUM_W'(e_q));
          cur_q     <= nxt_wl[WL_W] ? MAX18 : nxt_wl[WL_W-1:0];
          if (cnt_q != 16'hFFFF) cnt_q <= cnt_q + 16'd1;
          crv_sel_q <= 1'b0;
        end
        ST_OUT: begin
          out_valid_q <= 1'b1;
          par_sum_q   <= '0;
          ext_sum_q   <= '0;
          yld_sum_q   <= '0;
          lum_sum_q   <= '0;
          nrg_sum_q   <= '0;
          cnt_q       <= '0;
          cur_q       <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        e_q    <= bin_i.bin_irradiance;
        last_q <= bin_i.last_bin;
        lam_q  <= (cnt_q == '0) ? cfg.start_wavelength : cur_q;
      end
      ST_PQ_LO:  ahi_q <= prod[49:32];
      ST_PQ_HI:  t_q   <= prod[59:32];
      ST_PQ_SUM: q_q   <= pq_sum[45:8];
      ST_BD_MUL: begin
        if (!ov_ok) begin
          if (band_sel_q) ep_q <= '0;
          else pp_q <= '0;
        end
      end
      ST_BD_WAIT: begin
        if (div_done) begin
          if (band_sel_q) ep_q <= div_quot[Q_W-1:0];
          else pp_q <= div_quot[Q_W-1:0];
        end
      end
      ST_CV_CHK: if (!c_in) cval_q <= '0;
      ST_CV_IDX: begin
        i_q <= c_quo[IDX_W-1:0];
        f_q <= c_mod[STEP_W-1:0];
        if (c_quo[IDX_W-1:0] >= c_last) cval_q <= rom_at(crv_sel_q, c_last);
      end
      ST_CV_M2:  t_q <= prod[27:0];
      ST_CV_DIV: cval_q <= c_quo[CRV_W-1:0];
      ST_YIELD:  yp_q <= prod[53:16];
      ST_LUMW:   lp_q <= prod[48:16];
      ST_OUT: begin
        o_par_q <= par_sum_q;
        o_ext_q <= ext_sum_q;
        o_yld_q <= yld_sum_q;
        o_nrg_q <= nrg_sum_q;
        if ((lum_sum_q[SUM_W-1:MUL_A_W] != '0) || (prod[MUL_P_W-1:SUM_W] != '0)) begin
          o_lux_q <= MAX48;
        end else begin
          o_lux_q <= prod[SUM_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule
